// ===== hw/rtl/durs_pkg.sv =====
// Types and constants shared by the dual ultrasonic ranging scheduler.
`default_nettype none

package durs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_ECHO_OFF  = 3'd3,
    PH_ECHO_RISE = 3'd4,
    PH_ECHO_HIGH = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_TIMEOUT  = 2'd1,
    REG_MAX_DIST = 2'd2
  } cfg_reg_t;

  localparam int unsigned INTERVAL_W = 20;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned DIST_W     = 11;
  localparam int unsigned PTICK_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd50000;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd30000;
  localparam logic [DIST_W-1:0]     MAX_DIST_RST = 11'd400;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 20'hFFFFF;

  localparam logic [PTICK_W-1:0] LOW_TICKS  = 4'd2;
  localparam logic [PTICK_W-1:0] HIGH_TICKS = 4'd10;

  // duration * 10 / 582 == (duration * 5 * ceil(2^28 / 291)) >> 28 for 16-bit durations
  localparam int unsigned        RECIP_W     = 23;
  localparam int unsigned        RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_MUL   = 23'd4612295;

endpackage

`default_nettype wire

// ===== hw/rtl/durs_range_conv.sv =====
// Echo duration to distance conversion with range check.
`default_nettype none

module durs_range_conv
  import durs_pkg::*;
(
  input  wire logic [TIMEOUT_W-1:0] duration,
  input  wire logic [DIST_W-1:0]    max_distance_cm,
  output logic      [DIST_W-1:0]    distance_cm
);

  localparam int unsigned PROD_W = TIMEOUT_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] quot;

  assign prod = PROD_W'(duration) * PROD_W'(RECIP_MUL);
  assign quot = prod[RECIP_SHIFT +: DIST_W];

  always_comb begin
    if ((quot == '0) || (quot > max_distance_cm)) begin
      distance_cm = '0;
    end else begin
      distance_cm = quot;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_ultrasonic_ranging_scheduler.sv =====
// Top level of the dual ultrasonic ranging scheduler.
// Usage:
//   Present one input transfer per microsecond tick carrying both echo pin levels
//   (in_echo_left, in_echo_right). Each input transfer produces exactly one output
//   transfer: trigger drive levels for both sensors and, on the tick a measurement
//   ends, sample_valid with the sensor and distance in centimeters.
//   Sensors are measured in turn, left first; each measurement starts interval_us
//   ticks after the previous start, or right after the previous end if it overran.
//   out_valid rises once the transfer has passed the input register and then the
//   result register; one transfer is accepted every cycle while out_stall is low,
//   the state update and the constant-reciprocal distance multiply both fit in the
//   single pass.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while no transfer
//   is in flight; indexes 0..2 select interval_us, timeout_us, max_distance_cm.
//   Reset loads 50000, 30000 and 400 into those registers, empties both pipeline
//   registers and returns to idle with the left sensor next.
//   When out_stall is high the result register holds its transfer; in_stall rises
//   only once the input register is also full, so no transfer is lost.
`default_nettype none

module dual_ultrasonic_ranging_scheduler
  import durs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [INTERVAL_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_echo_left,
  input  wire logic                  in_echo_right,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_trig_left,
  output logic                       out_trig_right,
  output logic                       out_sample_valid,
  output logic                       out_sample_sensor,
  output logic [DIST_W-1:0]          out_distance_cm
);

  logic [INTERVAL_W-1:0] interval_us_r;
  logic [TIMEOUT_W-1:0]  timeout_us_r;
  logic [DIST_W-1:0]     max_dist_r;

  logic                  in_valid_r;
  logic                  echo_left_r;
  logic                  echo_right_r;

  phase_t                phase_r, phase_nxt;
  logic [PTICK_W-1:0]    phase_ticks_r, phase_ticks_nxt;
  logic [TIMEOUT_W-1:0]  wait_ticks_r, wait_ticks_nxt;
  logic [TIMEOUT_W-1:0]  pulse_ticks_r, pulse_ticks_nxt;
  logic [INTERVAL_W-1:0] interval_ticks_r, interval_ticks_nxt;
  logic                  sensor_turn_r, sensor_turn_nxt;

  logic                  out_valid_r;
  logic                  trig_left_r, trig_left_nxt;
  logic                  trig_right_r, trig_right_nxt;
  logic                  sample_valid_r, sample_valid_nxt;
  logic                  sample_sensor_r, sample_sensor_nxt;
  logic [DIST_W-1:0]     distance_r, distance_nxt;

  logic                  out_ready;
  logic                  adv;
  logic                  echo;
  logic                  trig;
  logic                  done;
  logic                  pulse_end;
  phase_t                ph;
  logic [TIMEOUT_W-1:0]  wait_inc;
  logic [DIST_W-1:0]     conv_dist;

  assign out_ready = !out_valid_r || !out_stall;
  assign adv       = in_valid_r && out_ready;
  assign in_stall  = in_valid_r && !out_ready;
  assign echo      = sensor_turn_r ? echo_right_r : echo_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_us_r <= INTERVAL_RST;
      timeout_us_r  <= TIMEOUT_RST;
      max_dist_r    <= MAX_DIST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL: interval_us_r <= cfg_wdata;
        REG_TIMEOUT:  timeout_us_r  <= cfg_wdata[TIMEOUT_W-1:0];
        REG_MAX_DIST: max_dist_r    <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      echo_left_r  <= in_echo_left;
      echo_right_r <= in_echo_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      phase_ticks_r    <= '0;
      wait_ticks_r     <= '0;
      pulse_ticks_r    <= '0;
      interval_ticks_r <= '0;
      sensor_turn_r    <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      phase_ticks_r    <= phase_ticks_nxt;
      wait_ticks_r     <= wait_ticks_nxt;
      pulse_ticks_r    <= pulse_ticks_nxt;
      interval_ticks_r <= interval_ticks_nxt;
      sensor_turn_r    <= sensor_turn_nxt;
    end
  end

  durs_range_conv u_conv (
    .duration        (pulse_ticks_r),
    .max_distance_cm (max_dist_r),
    .distance_cm     (conv_dist)
  );

  always_comb begin
    phase_nxt          = phase_r;
    phase_ticks_nxt    = phase_ticks_r;
    wait_ticks_nxt     = wait_ticks_r;
    pulse_ticks_nxt    = pulse_ticks_r;
    interval_ticks_nxt = interval_ticks_r;
    sensor_turn_nxt    = sensor_turn_r;
    trig               = 1'b0;
    done               = 1'b0;
    pulse_end          = 1'b0;
    ph                 = phase_r;
    wait_inc           = wait_ticks_r + TIMEOUT_W'(1);

    if (adv) begin
      if (interval_ticks_r != INTERVAL_MAX) begin
        interval_ticks_nxt = interval_ticks_r + INTERVAL_W'(1);
      end
      if ((ph == PH_IDLE) && (interval_ticks_nxt >= interval_us_r)) begin
        interval_ticks_nxt = '0;
        ph                 = PH_TRIG_LOW;
        phase_ticks_nxt    = '0;
      end

      case (ph)
        PH_IDLE: begin
        end
        PH_TRIG_LOW: begin
          phase_ticks_nxt = phase_ticks_nxt + PTICK_W'(1);
          if (phase_ticks_nxt >= LOW_TICKS) begin
            ph              = PH_TRIG_HIGH;
            phase_ticks_nxt = '0;
          end
        end
        PH_TRIG_HIGH: begin
          trig            = 1'b1;
          phase_ticks_nxt = phase_ticks_r + PTICK_W'(1);
          if (phase_ticks_nxt >= HIGH_TICKS) begin
            ph              = PH_ECHO_OFF;
            phase_ticks_nxt = '0;
            wait_ticks_nxt  = '0;
            pulse_ticks_nxt = '0;
          end
        end
        PH_ECHO_OFF, PH_ECHO_RISE, PH_ECHO_HIGH: begin
          if ((ph == PH_ECHO_OFF) && !echo) begin
            ph = PH_ECHO_RISE;
          end
          if ((ph == PH_ECHO_RISE) && echo) begin
            ph              = PH_ECHO_HIGH;
            pulse_ticks_nxt = '0;
          end else if ((ph == PH_ECHO_HIGH) && !echo) begin
            done      = 1'b1;
            pulse_end = 1'b1;
          end
          if ((ph == PH_ECHO_HIGH) && echo) begin
            pulse_ticks_nxt = pulse_ticks_nxt + TIMEOUT_W'(1);
          end
          if (!done) begin
            wait_ticks_nxt = wait_inc;
            if (wait_inc >= timeout_us_r) begin
              done = 1'b1;
            end
          end
        end
        default: begin
          ph = PH_IDLE;
        end
      endcase

      phase_nxt = ph;
      if (done) begin
        sensor_turn_nxt = !sensor_turn_r;
        phase_nxt       = PH_IDLE;
        phase_ticks_nxt = '0;
      end
    end

    trig_left_nxt     = trig && !sensor_turn_r;
    trig_right_nxt    = trig && sensor_turn_r;
    sample_valid_nxt  = done;
    sample_sensor_nxt = done && sensor_turn_r;
    distance_nxt      = pulse_end ? conv_dist : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trig_left_r     <= trig_left_nxt;
      trig_right_r    <= trig_right_nxt;
      sample_valid_r  <= sample_valid_nxt;
      sample_sensor_r <= sample_sensor_nxt;
      distance_r      <= distance_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trig_left     = trig_left_r;
  assign out_trig_right    = trig_right_r;
  assign out_sample_valid  = sample_valid_r;
  assign out_sample_sensor = sample_sensor_r;
  assign out_distance_cm   = distance_r;

  a_ptick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TRIG_HIGH) |-> (phase_ticks_r < HIGH_TICKS))
    else $error("trigger-high count past its end");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && done) |=> ((phase_r == PH_IDLE) && (sensor_turn_r != $past(sensor_turn_r))))
    else $error("finished measurement did not return to idle and swap sensor");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sample_valid_r) |-> (distance_r <= max_dist_r))
    else $error("reported distance above maximum");

  a_single_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(trig_left_r && trig_right_r))
    else $error("both triggers driven");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the dual ultrasonic ranging scheduler.
module tb
  import durs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic echo_left;
    logic echo_right;
  } echo_tick_t;

  typedef struct packed {
    logic              trig_left;
    logic              trig_right;
    logic              sample_valid;
    logic              sample_sensor;
    logic [DIST_W-1:0] distance_cm;
  } ranging_out_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_INTERVAL;
  logic [INTERVAL_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_echo_left = 1'b0;
  logic                  in_echo_right = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_trig_left;
  logic                  out_trig_right;
  logic                  out_sample_valid;
  logic                  out_sample_sensor;
  logic [DIST_W-1:0]     out_distance_cm;

  dual_ultrasonic_ranging_scheduler DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_echo_left      (in_echo_left),
    .in_echo_right     (in_echo_right),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trig_left     (out_trig_left),
    .out_trig_right    (out_trig_right),
    .out_sample_valid  (out_sample_valid),
    .out_sample_sensor (out_sample_sensor),
    .out_distance_cm   (out_distance_cm)
  );

  always #4 clk = ~clk;

  echo_tick_t   echo_ticks[$];
  ranging_out_t expected_readings[$];
  logic         idling = 1'b1;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;

  // predictor state and register copies
  phase_t                ph = PH_IDLE;
  logic [PTICK_W-1:0]    ph_ticks = '0;
  logic [TIMEOUT_W-1:0]  echo_wait = '0;
  logic [TIMEOUT_W-1:0]  pulse_len = '0;
  logic [INTERVAL_W-1:0] since_start = '0;
  logic                  next_right = 1'b0;
  logic [INTERVAL_W-1:0] set_interval = INTERVAL_RST;
  logic [TIMEOUT_W-1:0]  set_timeout = TIMEOUT_RST;
  logic [DIST_W-1:0]     set_max_dist = MAX_DIST_RST;

  // echo pulse generator state
  logic [1:0]  pin_level = '0;
  int unsigned pin_run[2] = '{0, 0};

  function automatic ranging_out_t step_ranging(input echo_tick_t t);
    ranging_out_t         r;
    logic                 side;
    logic                 echo;
    logic                 trig;
    logic                 fired;
    logic [TIMEOUT_W-1:0] dur;
    logic [31:0]          cm;
    r = '0;
    side = next_right;
    echo = side ? t.echo_right : t.echo_left;
    trig = 1'b0;
    fired = 1'b0;
    dur = '0;
    if (since_start != INTERVAL_MAX) since_start = since_start + 1'b1;
    if (ph == PH_IDLE && since_start >= set_interval) begin
      since_start = '0;
      ph = PH_TRIG_LOW;
      ph_ticks = '0;
    end
    case (ph)
      PH_TRIG_LOW: begin
        ph_ticks = ph_ticks + 1'b1;
        if (ph_ticks >= LOW_TICKS) begin
          ph = PH_TRIG_HIGH;
          ph_ticks = '0;
        end
      end
      PH_TRIG_HIGH: begin
        trig = 1'b1;
        ph_ticks = ph_ticks + 1'b1;
        if (ph_ticks >= HIGH_TICKS) begin
          ph = PH_ECHO_OFF;
          ph_ticks = '0;
          echo_wait = '0;
          pulse_len = '0;
        end
      end
      PH_ECHO_OFF, PH_ECHO_RISE, PH_ECHO_HIGH: begin
        if (ph == PH_ECHO_OFF && !echo) ph = PH_ECHO_RISE;
        if (ph == PH_ECHO_RISE && echo) begin
          ph = PH_ECHO_HIGH;
          pulse_len = '0;
        end else if (ph == PH_ECHO_HIGH && !echo) begin
          fired = 1'b1;
          dur = pulse_len;
        end
        if (ph == PH_ECHO_HIGH && echo) pulse_len = pulse_len + 1'b1;
        if (!fired) begin
          echo_wait = echo_wait + 1'b1;
          if (echo_wait >= set_timeout) fired = 1'b1;
        end
      end
      default: ;
    endcase
    r.trig_left = trig && !side;
    r.trig_right = trig && side;
    if (fired) begin
      cm = ({16'd0, dur} * 32'd10) / 32'd582;
      r.sample_valid = 1'b1;
      r.sample_sensor = side;
      r.distance_cm = (cm == 32'd0 || cm > {21'd0, set_max_dist}) ? '0 : cm[DIST_W-1:0];
      next_right = !side;
      ph = PH_IDLE;
      ph_ticks = '0;
    end
    return r;
  endfunction

  function automatic echo_tick_t next_echo();
    echo_tick_t t;
    for (int p = 0; p < 2; p++) begin
      if (pin_run[p] == 0) begin
        pin_level[p] = !pin_level[p];
        if (!pin_level[p]) begin
          pin_run[p] = $urandom_range(1, 30);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pin_run[p] = $urandom_range(55, 220);
            6, 7:             pin_run[p] = $urandom_range(1, 58);
            8:                pin_run[p] = $urandom_range(221, 700);
            default:          pin_run[p] = $urandom_range(1, 4);
          endcase
        end
      end
      pin_run[p] = pin_run[p] - 1;
    end
    t.echo_left = pin_level[0];
    t.echo_right = pin_level[1];
    if ($urandom_range(0, 9) == 0) t = echo_tick_t'(2'($urandom_range(0, 3)));
    return t;
  endfunction

  function automatic bit drained();
    return echo_ticks.size() == 0 && !in_valid && expected_readings.size() == 0;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [INTERVAL_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_INTERVAL: set_interval = val;
      REG_TIMEOUT:  set_timeout = val[TIMEOUT_W-1:0];
      REG_MAX_DIST: set_max_dist = val[DIST_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [INTERVAL_W-1:0] ivl, input logic [INTERVAL_W-1:0] tmo,
                              input logic [INTERVAL_W-1:0] dmax, input bit spare);
    do @(negedge clk); while (!drained());
    @(posedge clk);
    write_reg(REG_INTERVAL, ivl);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_MAX_DIST, dmax);
    if (spare) write_reg(REG_SPARE, '1);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_echo_train(input int unsigned count);
    repeat (count) echo_ticks.push_back(next_echo());
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  int unsigned send_gap = 0;

  always @(posedge clk) begin
    echo_tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        expected_readings.push_back(step_ranging(echo_tick_t'({in_echo_left, in_echo_right})));
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (echo_ticks.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else begin
        nxt = echo_ticks.pop_front();
        in_valid <= 1'b1;
        in_echo_left <= nxt.echo_left;
        in_echo_right <= nxt.echo_right;
      end
    end
  end

  int unsigned stall_left = 0;

  always @(posedge clk) begin
    ranging_out_t got;
    ranging_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_trig_left, out_trig_right, out_sample_valid, out_sample_sensor,
              out_distance_cm};
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 1);
      end else begin
        want = expected_readings.pop_front();
        if (got.trig_left !== want.trig_left)
          report_mismatch("trig_left", want.trig_left, got.trig_left);
        if (got.trig_right !== want.trig_right)
          report_mismatch("trig_right", want.trig_right, got.trig_right);
        if (got.sample_valid !== want.sample_valid)
          report_mismatch("sample_valid", want.sample_valid, got.sample_valid);
        if (got.sample_sensor !== want.sample_sensor)
          report_mismatch("sample_sensor", want.sample_sensor, got.sample_sensor);
        if (got.distance_cm !== want.distance_cm)
          report_mismatch("distance_cm", want.distance_cm, got.distance_cm);
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 4; i++) echo_ticks.push_back(echo_tick_t'(i[1:0]));
    program_regs(20'd0, 20'd0, 20'd0, 1'b0);
    for (int i = 0; i < 21; i++) echo_ticks.push_back(echo_tick_t'(i[1:0]));
    program_regs(20'd1, 20'd250, 20'd1126, 1'b0);
    queue_echo_train(250);
    program_regs(20'd40, 20'd65535, 20'd1, 1'b0);
    queue_echo_train(200);
    program_regs(20'd0, 20'hF012C, 20'd0, 1'b1);
    queue_echo_train(150);
    program_regs(20'd200, 20'd100, 20'hFFFFF, 1'b0);
    queue_echo_train(200);
    program_regs(20'hFFFFF, 20'd1, 20'd400, 1'b0);
    queue_echo_train(60);
    program_regs(20'd13, 20'd30000, 20'd400, 1'b0);
    queue_echo_train(200);
    program_regs(20'd5, 20'd150, 20'd3, 1'b0);
    idling = 1'b0;
    queue_echo_train(240);
    do @(negedge clk); while (!drained());
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/durs_pkg.sv
hw/rtl/durs_range_conv.sv
hw/rtl/dual_ultrasonic_ranging_scheduler.sv
tb/tb.sv
